// File: rtl/tsf_pkg.sv
// Shared types, codes and helpers for the tilemap scanline fetcher.
// No dependencies; used by every module under rtl.
package tsf_pkg;

   localparam int unsigned ScreenWidthDefault = 640;

   localparam logic Cmd_START = 1'b0;
   localparam logic Cmd_TILE  = 1'b1;

   localparam logic [1:0] Kind_FETCH = 2'd0;
   localparam logic [1:0] Kind_COPY  = 2'd1;
   localparam logic [1:0] Kind_SKIP  = 2'd2;
   localparam logic [1:0] Kind_EMPTY = 2'd3;

   localparam logic [1:0] Mode_8BPP  = 2'd2;
   localparam logic [1:0] Mode_WIDE  = 2'd1;

   localparam logic [2:0] Reg_TILE_SIZE = 3'd0;
   localparam logic [2:0] Reg_MAP_WLOG  = 3'd1;
   localparam logic [2:0] Reg_MAP_H     = 3'd2;
   localparam logic [2:0] Reg_POS_X     = 3'd3;
   localparam logic [2:0] Reg_POS_RY    = 3'd4;
   localparam logic [2:0] Reg_OBJ_W     = 3'd5;
   localparam logic [2:0] Reg_MODE      = 3'd6;

   typedef struct packed {
      logic [1:0]  tile_size_code;
      logic [3:0]  map_width_log2;
      logic [11:0] map_height;
      logic [11:0] pos_x;
      logic [11:0] pos_ry;
      logic [11:0] obj_width;
      logic [1:0]  render_mode;
   } cfg_type;

   typedef struct packed {
      logic        command;
      logic [10:0] line_number;
      logic [15:0] tile_index;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] map_entry;
      logic [11:0] dst_pos;
      logic [25:0] src_offset;
      logic [5:0]  pixel_count;
      logic        last;
   } result_type;

   // Tile edge in pixels; code three behaves as 16.
   function automatic logic [5:0] tile_edge(input logic [1:0] code);
      case (code)
         2'd1:    tile_edge = 6'd32;
         2'd2:    tile_edge = 6'd8;
         default: tile_edge = 6'd16;
      endcase
   endfunction

   // log2 of the tile edge.
   function automatic logic [2:0] tile_shift(input logic [1:0] code);
      case (code)
         2'd1:    tile_shift = 3'd5;
         2'd2:    tile_shift = 3'd3;
         default: tile_shift = 3'd4;
      endcase
   endfunction

endpackage

// File: rtl/tsf_csr.sv
// Configuration register file with an APB-style port.
// Depends on tsf_pkg for the register layout and indexes.
module tsf_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output tsf_pkg::cfg_type   cfg
);
   import tsf_pkg::*;

   cfg_type     cfg_ff;
   logic [2:0]  index;
   logic        write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{tile_size_code: 2'd0, map_width_log2: 4'd5, map_height: 12'd32,
                     pos_x: 12'd0, pos_ry: 12'd0, obj_width: 12'd0, render_mode: 2'd0};
      end else if (write_en) begin
         unique case (index)
            Reg_TILE_SIZE: cfg_ff.tile_size_code <= csr_pwdata[1:0];
            Reg_MAP_WLOG:  cfg_ff.map_width_log2 <= csr_pwdata[3:0];
            Reg_MAP_H:     cfg_ff.map_height     <= csr_pwdata[11:0];
            Reg_POS_X:     cfg_ff.pos_x          <= csr_pwdata[11:0];
            Reg_POS_RY:    cfg_ff.pos_ry         <= csr_pwdata[11:0];
            Reg_OBJ_W:     cfg_ff.obj_width      <= csr_pwdata[11:0];
            Reg_MODE:      cfg_ff.render_mode    <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         Reg_TILE_SIZE: csr_prdata[1:0]  = cfg_ff.tile_size_code;
         Reg_MAP_WLOG:  csr_prdata[3:0]  = cfg_ff.map_width_log2;
         Reg_MAP_H:     csr_prdata[11:0] = cfg_ff.map_height;
         Reg_POS_X:     csr_prdata[11:0] = cfg_ff.pos_x;
         Reg_POS_RY:    csr_prdata[11:0] = cfg_ff.pos_ry;
         Reg_OBJ_W:     csr_prdata[11:0] = cfg_ff.obj_width;
         Reg_MODE:      csr_prdata[1:0]  = cfg_ff.render_mode;
         default:       csr_prdata = '0;
      endcase
   end

endmodule

// File: rtl/tsf_queue.sv
// Short item queue between the front and back parts.
// Depends on tsf_pkg for the item type.
module tsf_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tsf_pkg::item_type  push_data,
   output logic               full,
   input  logic               pop,
   output tsf_pkg::item_type  pop_data,
   output logic               empty
);
   import tsf_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     count_ff;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push && !full)
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop && !empty)
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         count_ff <= count_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
      end
   end

   count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |=> !(count_ff == '1)) else $error("queue count underflow");
   push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !pop) |=> !empty) else $error("queue lost a beat");

endmodule

// File: rtl/tsf_engine.sv
// Back part: carries out start-line and tile items and emits result beats.
// Depends on tsf_pkg; takes items from tsf_queue and config from tsf_csr.
module tsf_engine #(
   parameter int unsigned SCREEN_WIDTH = tsf_pkg::ScreenWidthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsf_pkg::cfg_type     cfg,
   input  logic                 item_valid,
   input  tsf_pkg::item_type    item,
   output logic                 item_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output tsf_pkg::result_type  rsp_beat
);
   import tsf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_START, S_OUT1, S_OUT2
   } state_type;

   state_type   state_ff;
   logic [23:0] row_base_ff;
   logic [4:0]  row_in_tile_ff;
   logic [10:0] tile_column_ff;
   logic [12:0] screen_pos_ff;
   logic [11:0] screen_end_ff;
   logic [4:0]  partial_first_ff;
   logic        line_active_ff;
   // Line offset remainder, reduced one step per cycle by restoring division.
   logic [11:0] rem_ff;
   logic        rem_neg_ff;
   logic [17:0] period_ff;
   logic [3:0]  step_ff;
   result_type  out1_ff, out2_ff;
   logic        has2_ff;

   logic [5:0]  ts;
   logic [2:0]  tsh;
   logic [3:0]  wlog;
   logic [10:0] wmask;
   logic [12:0] hgt;
   logic signed [12:0] x_al, ry;
   logic signed [13:0] diff;
   logic signed [13:0] endx;
   logic [12:0] startx;
   logic [11:0] neg;
   logic [11:0] diff_mag;
   logic [25:0] sub_val;
   logic [17:0] m_val;
   logic [23:0] row_base_new;
   logic [10:0] column_new;
   logic [25:0] src;
   logic [4:0]  col;
   logic [5:0]  cnt;
   logic [12:0] pos_next;
   logic        lastb;
   logic [15:0] idx;

   always_comb begin
      ts    = tile_edge(cfg.tile_size_code);
      tsh   = tile_shift(cfg.tile_size_code);
      wlog  = (cfg.map_width_log2 > 4'd11) ? 4'd11 : cfg.map_width_log2;
      wmask = 11'((12'd1 << wlog) - 12'd1);
      hgt   = (cfg.map_height == 12'd0) ? 13'd4096 : {1'b0, cfg.map_height};
      x_al  = 13'(signed'(cfg.pos_x));
      x_al  = (cfg.render_mode == Mode_8BPP) ? (x_al & ~13'sd3) : (x_al & ~13'sd1);
      ry    = 13'(signed'(cfg.pos_ry));
      diff  = 14'(signed'({2'b00, item.line_number})) - 14'(ry);
      diff_mag = diff[13] ? 12'(-diff) : 12'(diff);
      endx  = 14'(x_al) + 14'(signed'({2'b00, cfg.obj_width}));
      if (endx > $signed(14'(SCREEN_WIDTH))) endx = $signed(14'(SCREEN_WIDTH));
      startx = x_al[12] ? 13'd0 : 13'(x_al);
      neg    = x_al[12] ? 12'(-x_al) : 12'd0;
      sub_val = 26'(period_ff) << step_ff;
      // A negative offset folds back to period minus its remainder.
      m_val  = (rem_neg_ff && rem_ff != 12'd0) ? period_ff - 18'(rem_ff)
                                               : 18'(rem_ff);
      row_base_new = ({6'd0, m_val} >> tsh) << wlog;
      column_new   = 11'(neg >> tsh) & wmask;
      idx    = (cfg.render_mode == Mode_WIDE) ? item.tile_index
                                              : {8'd0, item.tile_index[7:0]};
      col    = ({1'b0, partial_first_ff} < ts) ? partial_first_ff : 5'd0;
      cnt    = ts - {1'b0, col};
      pos_next = screen_pos_ff + 13'(cnt);
      lastb  = (pos_next >= {1'b0, screen_end_ff});
      // (idx-1)*ts*ts; ts*ts is a power of two, so a shift.
      src    = 26'(({15'd0, 16'(idx - 16'd1)} << {tsh, 1'b0}) & 31'h3ffffff)
             + 26'({row_in_tile_ff, 5'd0} >> (3'd5 - tsh)) + 26'(col);
   end

   assign item_pop   = (state_ff == S_IDLE) && item_valid;
   assign rsp_tvalid = (state_ff == S_OUT1) || (state_ff == S_OUT2);
   assign rsp_beat   = (state_ff == S_OUT2) ? out2_ff : out1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         line_active_ff <= 1'b0;
         row_base_ff    <= '0;
         row_in_tile_ff <= '0;
         tile_column_ff <= '0;
         screen_pos_ff  <= '0;
         screen_end_ff  <= '0;
         partial_first_ff <= '0;
         has2_ff        <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  if (item.command == Cmd_START) begin
                     // Positive modulo: reduce the offset magnitude first.
                     period_ff  <= 18'(hgt) << tsh;
                     rem_ff     <= diff_mag;
                     rem_neg_ff <= diff[13];
                     step_ff    <= 4'd8;
                     state_ff   <= S_MOD;
                  end else if (line_active_ff) begin
                     screen_pos_ff    <= pos_next;
                     tile_column_ff   <= (tile_column_ff + 11'd1) & wmask;
                     partial_first_ff <= '0;
                     out1_ff <= '{kind: (idx != 0) ? Kind_COPY : Kind_SKIP,
                                  map_entry: '0, dst_pos: screen_pos_ff[11:0],
                                  src_offset: (idx != 0) ? src : 26'd0,
                                  pixel_count: cnt, last: lastb};
                     out2_ff <= '{kind: Kind_FETCH,
                                  map_entry: row_base_ff + 24'((tile_column_ff + 11'd1) & wmask),
                                  dst_pos: '0, src_offset: '0, pixel_count: '0, last: 1'b0};
                     has2_ff <= !lastb;
                     if (lastb) line_active_ff <= 1'b0;
                     state_ff <= S_OUT1;
                  end
               end
            end
            S_MOD: begin
               // Subtract period << step when it fits.
               if ({14'd0, rem_ff} >= sub_val)
                  rem_ff <= 12'({14'd0, rem_ff} - sub_val);
               if (step_ff == 4'd0) state_ff <= S_START;
               else step_ff <= step_ff - 4'd1;
            end
            S_START: begin
               row_in_tile_ff <= 5'(m_val & 18'(ts - 6'd1));
               row_base_ff    <= row_base_new;
               has2_ff        <= 1'b0;
               if (endx <= $signed({1'b0, startx})) begin
                  line_active_ff <= 1'b0;
                  out1_ff <= '{kind: Kind_EMPTY, map_entry: '0, dst_pos: '0,
                               src_offset: '0, pixel_count: '0, last: 1'b1};
               end else begin
                  tile_column_ff   <= column_new;
                  partial_first_ff <= 5'(neg & 12'(ts - 6'd1));
                  screen_pos_ff    <= startx;
                  screen_end_ff    <= 12'(endx);
                  line_active_ff   <= 1'b1;
                  out1_ff <= '{kind: Kind_FETCH,
                               map_entry: row_base_new + 24'(column_new),
                               dst_pos: '0, src_offset: '0, pixel_count: '0, last: 1'b0};
               end
               state_ff <= S_OUT1;
            end
            S_OUT1: if (rsp_tready) state_ff <= has2_ff ? S_OUT2 : S_IDLE;
            S_OUT2: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_beat.last) |=> !line_active_ff)
      else $error("line still active after last beat");
   second_is_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT2) |-> (rsp_beat.kind == Kind_FETCH))
      else $error("second beat is not a fetch");
   no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (state_ff == S_IDLE)) else $error("pop while busy");

endmodule

// File: rtl/tilemap_scanline_fetcher.sv
// Tilemap scanline fetcher, top level.
// Request channel (req_*): start-line beats (command 0, line number) and tile
// beats (command 1, fetched map entry value). Response channel (rsp_*): fetch
// requests, copy/skip descriptors and the empty-line marker; tlast marks the
// final beat of a scanline. Configuration goes through the csr_* APB port.
// The front accepts request beats into a two-entry queue whenever it has room,
// so the sender is not held up while a response waits. The back part takes one
// beat at a time and finishes its responses before taking the next; a start-line
// beat first runs the bit-serial positive modulo of the line offset by the map
// period (9 steps). When the receiver stalls, the response holds and the back part
// waits; the queue then fills and req_tready drops.
// Reset is synchronous: the configuration registers return to their defaults and the line goes
// idle. Tile beats while idle produce nothing.
// Depends on tsf_pkg, tsf_csr, tsf_queue and tsf_engine.
module tilemap_scanline_fetcher #(
   parameter int unsigned SCREEN_WIDTH = tsf_pkg::ScreenWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // line_number[10:0], tile_index[26:11], zero pad
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // map_entry[23:0], dst_pos[35:24],
                                    // src_offset[61:36], pixel_count[67:62], pad
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tsf_pkg::*;

   cfg_type    cfg;
   item_type   in_item, q_item;
   result_type beat;
   logic       q_full, q_empty, q_pop;

   assign in_item = '{command: req_tuser, line_number: req_tdata[10:0],
                      tile_index: req_tdata[26:11]};
   assign req_tready = !q_full;

   tsf_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   tsf_queue #(.DEPTH(2)) u_queue (
      .clock, .reset, .push(req_tvalid), .push_data(in_item), .full(q_full),
      .pop(q_pop), .pop_data(q_item), .empty(q_empty)
   );

   tsf_engine #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_engine (
      .clock, .reset, .cfg, .item_valid(!q_empty), .item(q_item),
      .item_pop(q_pop), .rsp_tvalid, .rsp_tready, .rsp_beat(beat)
   );

   assign rsp_tdata = {4'd0, beat.pixel_count, beat.src_offset, beat.dst_pos,
                       beat.map_entry};
   assign rsp_tuser = beat.kind;
   assign rsp_tlast = beat.last;

endmodule
